// ----- sv/rtdc_pkg.sv -----
package rtdc_pkg;

	localparam int MAX_PATH_W  = 12;
	localparam int MAX_QUERY_W = 10;
	localparam int QUERY_CNT_W = 11;
	localparam int CFG_DATA_W  = 12;
	localparam int CFG_IDX_W   = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH_LEN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_QUERY_LEN = 1'd1;

	localparam logic [MAX_PATH_W-1:0]  MAX_PATH_RESET  = 12'd1023;
	localparam logic [MAX_QUERY_W-1:0] MAX_QUERY_RESET = 10'd255;
	localparam logic [QUERY_CNT_W-1:0] QUERY_SAT       = 11'd2047;

	localparam logic [7:0] CH_QMARK     = 8'h3f;
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_PERCENT   = 8'h25;
	localparam logic [7:0] CH_DOT       = 8'h2e;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_DEL       = 8'h7f;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef logic [1:0] esc_phase_t;
	localparam esc_phase_t ESC_NONE = 2'd0;
	localparam esc_phase_t ESC_HIGH = 2'd1;
	localparam esc_phase_t ESC_LOW  = 2'd2;

	typedef logic [1:0] seg_phase_t;
	localparam seg_phase_t SEG_START = 2'd0;
	localparam seg_phase_t SEG_DOT1  = 2'd1;
	localparam seg_phase_t SEG_DOT2  = 2'd2;
	localparam seg_phase_t SEG_OTHER = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_BAD       = 2'd1;
	localparam status_t ST_TOO_LONG  = 2'd2;
	localparam status_t ST_FORBIDDEN = 2'd3;

	typedef struct packed {
		logic unsafe;
		logic decode;
		logic no_slash;
		logic too_long;
	} err_flags_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} nibble_t;

	function automatic nibble_t hex_nibble(input logic [7:0] c);
		nibble_t n;
		n.valid = 1'b1;
		n.value = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			n.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			n.value = c[3:0] + 4'd9;
		end else begin
			n.valid = 1'b0;
		end
		return n;
	endfunction

endpackage

// ----- sv/request_target_decode_check_core.sv -----
// Percent-decodes the path of an HTTP request target and checks it, one byte per
// transaction with a last flag on the final byte. Path bytes (before the first '?') come
// out decoded; query bytes come out raw until max_query_len of them have passed. Every
// input transaction yields exactly one result transaction, and the one for the last byte
// carries the verdict in status, after which all per-target state is cleared. The block
// takes one byte per cycle unless stalled: a byte is held in an input register, decoded and
// checked by a single level of logic against the per-target state, and written to the result
// register; while a result is stalled the input register can take one more byte, then stalls.
// Configuration writes take effect at once and are meant to be made between targets.
module request_target_decode_check_core #(
	parameter int LEN_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rtdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rtdc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       in_byte,
	input  logic                             last,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic                             out_valid,
	output logic [7:0]                       out_byte,
	output logic                             in_query,
	output logic                             done_res,
	output logic [1:0]                       status
);
	import rtdc_pkg::*;

	localparam int CMP_W = (LEN_BITS > MAX_PATH_W) ? LEN_BITS : MAX_PATH_W;
	localparam logic [LEN_BITS-1:0] PATH_SAT = {LEN_BITS{1'b1}};

	logic [MAX_PATH_W-1:0]  max_path_len_q;
	logic [MAX_QUERY_W-1:0] max_query_len_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	esc_phase_t             esc_q, esc_n;
	logic [3:0]             hi_q, hi_n;
	seg_phase_t             seg_q, seg_n;
	logic [LEN_BITS-1:0]    pc_q, pc_n;
	logic [QUERY_CNT_W-1:0] qc_q, qc_n;
	logic                   qs_q, qs_n;
	logic                   fp_q, fp_n;
	err_flags_t             err_q, err_n;

	logic       res_valid_q;
	logic       ov_q, oq_q, done_q;
	logic [7:0] ob_q;
	status_t    st_q;

	logic       ov, oq;
	logic [7:0] ob;
	status_t    st;
	logic       advance;
	logic       step;

	assign advance  = !res_valid_q || !res_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_path_len_q  <= MAX_PATH_RESET;
			max_query_len_q <= MAX_QUERY_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAX_PATH_LEN) begin
				max_path_len_q <= cfg_data[MAX_PATH_W-1:0];
			end else if (cfg_index == REG_MAX_QUERY_LEN) begin
				max_query_len_q <= cfg_data[MAX_QUERY_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= last;
		end
	end

	always_comb begin
		nibble_t    nib;
		logic       dec_en;
		logic [7:0] dec;
		logic       qmark_path;
		logic       do_end;

		esc_n = esc_q;
		hi_n  = hi_q;
		seg_n = seg_q;
		pc_n  = pc_q;
		qc_n  = qc_q;
		qs_n  = qs_q;
		fp_n  = fp_q;
		err_n = err_q;
		ov    = 1'b0;
		ob    = 8'd0;
		oq    = 1'b0;
		st    = ST_OK;
		dec_en = 1'b0;
		dec    = byte_s1;
		qmark_path = 1'b0;
		nib = hex_nibble(byte_s1);

		if (qs_q) begin
			if (qc_q < {1'b0, max_query_len_q}) begin
				ov = 1'b1;
				ob = byte_s1;
				oq = 1'b1;
			end
			if (qc_q != QUERY_SAT) begin
				qc_n = qc_q + 1'b1;
			end
		end else if (byte_s1 == CH_QMARK) begin
			if (fp_q) begin
				err_n.no_slash = 1'b1;
			end
			fp_n = 1'b0;
			qmark_path = 1'b1;
			qs_n = 1'b1;
		end else begin
			if (fp_q && byte_s1 != CH_SLASH) begin
				err_n.no_slash = 1'b1;
			end
			fp_n = 1'b0;
			if (CMP_W'(pc_q) >= CMP_W'(max_path_len_q)) begin
				err_n.too_long = 1'b1;
			end
			if (pc_q != PATH_SAT) begin
				pc_n = pc_q + 1'b1;
			end
			if (!err_q.decode) begin
				if (esc_q == ESC_NONE) begin
					if (byte_s1 == CH_PERCENT) begin
						esc_n = ESC_HIGH;
					end else begin
						dec_en = 1'b1;
					end
				end else if (!nib.valid) begin
					err_n.decode = 1'b1;
					esc_n = ESC_NONE;
				end else if (esc_q == ESC_HIGH) begin
					hi_n  = nib.value;
					esc_n = ESC_LOW;
				end else begin
					esc_n = ESC_NONE;
					dec   = {hi_q, nib.value};
					if (dec == 8'd0) begin
						err_n.decode = 1'b1;
					end else begin
						dec_en = 1'b1;
					end
				end
			end
		end

		if (dec_en) begin
			ov = 1'b1;
			ob = dec;
			if (dec < CH_SPACE || dec == CH_DEL || dec == CH_BACKSLASH) begin
				err_n.unsafe = 1'b1;
			end
			if (dec == CH_SLASH) begin
				if (seg_q == SEG_DOT2) begin
					err_n.unsafe = 1'b1;
				end
				seg_n = SEG_START;
			end else if (dec == CH_DOT) begin
				if (seg_q != SEG_OTHER) begin
					seg_n = seg_q + 2'd1;
				end
			end else begin
				seg_n = SEG_OTHER;
			end
		end

		// The path closes at the first '?' or at the end of a target without a query.
		do_end = qmark_path || (last_s1 && !qs_n);
		if (do_end && !err_n.decode) begin
			if (esc_n != ESC_NONE) begin
				err_n.decode = 1'b1;
				esc_n = ESC_NONE;
			end else if (seg_n == SEG_DOT2) begin
				err_n.unsafe = 1'b1;
			end
		end

		if (last_s1) begin
			priority if (err_n.too_long) begin
				st = ST_TOO_LONG;
			end else if (err_n.no_slash || err_n.decode) begin
				st = ST_BAD;
			end else if (err_n.unsafe) begin
				st = ST_FORBIDDEN;
			end else begin
				st = ST_OK;
			end
			esc_n = ESC_NONE;
			hi_n  = 4'd0;
			seg_n = SEG_START;
			pc_n  = '0;
			qc_n  = '0;
			qs_n  = 1'b0;
			fp_n  = 1'b1;
			err_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESC_NONE;
			hi_q  <= 4'd0;
			seg_q <= SEG_START;
			pc_q  <= '0;
			qc_q  <= '0;
			qs_q  <= 1'b0;
			fp_q  <= 1'b1;
			err_q <= '0;
		end else if (step) begin
			esc_q <= esc_n;
			hi_q  <= hi_n;
			seg_q <= seg_n;
			pc_q  <= pc_n;
			qc_q  <= qc_n;
			qs_q  <= qs_n;
			fp_q  <= fp_n;
			err_q <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ov_q   <= ov;
			ob_q   <= ob;
			oq_q   <= oq;
			done_q <= last_s1;
			st_q   <= st;
		end
	end

	assign res_valid = res_valid_q;
	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign in_query  = oq_q;
	assign done_res  = done_q;
	assign status    = st_q;

	a_status_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !done_res |-> status == ST_OK)
		else $error("status set on a result that is not the last of a target");

	a_idle_byte_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_byte == 8'd0 && !in_query)
		else $error("byte or query mark set without a carried byte");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled while the pipeline can move");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_s1 |=> fp_q && !qs_q && err_q == '0)
		else $error("per-target state not cleared after the last byte");

endmodule

// ----- bench/tb_request_target_decode_check_core.sv -----
module tb_request_target_decode_check_core;
	import rtdc_pkg::*;

	localparam logic [11:0] PATH_SAT = 12'hfff;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic       ov;
		logic [7:0] ob;
		logic       oq;
		logic       done;
		status_t    verdict;
	} decoded_t;

	class target_scoreboard;
		logic [11:0] max_path;
		logic [9:0]  max_query;
		esc_phase_t  esc;
		logic [3:0]  hi;
		seg_phase_t  seg;
		logic [11:0] path_count;
		logic [10:0] query_count;
		logic        query_seen;
		logic        first_pending;
		err_flags_t  flags;
		decoded_t    decoded_q[$];
		int          mismatches;

		function new();
			max_path = MAX_PATH_RESET;
			max_query = MAX_QUERY_RESET;
			mismatches = 0;
			clear_target();
		endfunction

		function void set_limits(input logic [11:0] mp, input logic [9:0] mq);
			max_path = mp;
			max_query = mq;
		endfunction

		function void clear_target();
			esc = ESC_NONE;
			hi = 4'd0;
			seg = SEG_START;
			path_count = '0;
			query_count = '0;
			query_seen = 1'b0;
			first_pending = 1'b1;
			flags = '0;
		endfunction

		function int hex_value(input logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
			return -1;
		endfunction

		function void close_path();
			if (flags.decode) return;
			if (esc != ESC_NONE) begin
				flags.decode = 1'b1;
				esc = ESC_NONE;
				return;
			end
			if (seg == SEG_DOT2) flags.unsafe = 1'b1;
		endfunction

		function void screen_byte(input logic [7:0] d);
			if (d < CH_SPACE || d == CH_DEL || d == CH_BACKSLASH) flags.unsafe = 1'b1;
			if (d == CH_SLASH) begin
				if (seg == SEG_DOT2) flags.unsafe = 1'b1;
				seg = SEG_START;
			end else if (d == CH_DOT) begin
				if (seg != SEG_OTHER) seg = seg + 2'd1;
			end else begin
				seg = SEG_OTHER;
			end
		endfunction

		function void take_byte(input logic [7:0] b, input logic l);
			decoded_t r;
			int n;
			logic [7:0] v;
			r = '0;
			if (query_seen) begin
				if (query_count < {1'b0, max_query}) begin
					r.ov = 1'b1;
					r.ob = b;
					r.oq = 1'b1;
				end
				if (query_count < QUERY_SAT) query_count++;
			end else if (b == CH_QMARK) begin
				if (first_pending) flags.no_slash = 1'b1;
				first_pending = 1'b0;
				close_path();
				query_seen = 1'b1;
			end else begin
				if (first_pending && b != CH_SLASH) flags.no_slash = 1'b1;
				first_pending = 1'b0;
				if (path_count >= max_path) flags.too_long = 1'b1;
				if (path_count < PATH_SAT) path_count++;
				if (!flags.decode) begin
					if (esc == ESC_NONE) begin
						if (b == CH_PERCENT) begin
							esc = ESC_HIGH;
						end else begin
							r.ov = 1'b1;
							r.ob = b;
							screen_byte(b);
						end
					end else begin
						n = hex_value(b);
						if (n < 0) begin
							flags.decode = 1'b1;
							esc = ESC_NONE;
						end else if (esc == ESC_HIGH) begin
							hi = n[3:0];
							esc = ESC_LOW;
						end else begin
							v = {hi, n[3:0]};
							esc = ESC_NONE;
							if (v == 8'h00) begin
								flags.decode = 1'b1;
							end else begin
								r.ov = 1'b1;
								r.ob = v;
								screen_byte(v);
							end
						end
					end
				end
			end
			if (l) begin
				if (!query_seen) close_path();
				r.done = 1'b1;
				if (flags.too_long) r.verdict = ST_TOO_LONG;
				else if (flags.no_slash || flags.decode) r.verdict = ST_BAD;
				else if (flags.unsafe) r.verdict = ST_FORBIDDEN;
				else r.verdict = ST_OK;
				clear_target();
			end
			decoded_q.push_back(r);
		endfunction

		function void compare_field(input string name, input int e, input int a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
				mismatches++;
			end
		endfunction

		function void match_result(input decoded_t got);
			decoded_t e;
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				mismatches++;
				return;
			end
			e = decoded_q.pop_front();
			compare_field("out_valid", e.ov, got.ov);
			compare_field("out_byte", e.ob, got.ob);
			compare_field("in_query", e.oq, got.oq);
			compare_field("done_res", e.done, got.done);
			compare_field("status", e.verdict, got.verdict);
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_PATH_LEN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_byte = 8'h00;
	logic                  last = 1'b0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic                  out_valid;
	logic [7:0]            out_byte;
	logic                  in_query;
	logic                  done_res;
	logic [1:0]            status;

	target_scoreboard sb;
	logic [7:0] bytes_q[$];
	int idle_cycles = 0;
	int send_idle_on = 1;
	int recv_idle_on = 1;
	int hold_pending = 0;
	string safe_chars =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_~";

	request_target_decode_check_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.last(last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.in_query(in_query),
		.done_res(done_res),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin : monitor
		decoded_t got;
		logic moved;
		moved = 1'b0;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				got.ov = out_valid;
				got.ob = out_byte;
				got.oq = in_query;
				got.done = done_res;
				got.verdict = status;
				sb.match_result(got);
				moved = 1'b1;
			end
			if (in_valid && !in_stall) begin
				sb.take_byte(in_byte, last);
				moved = 1'b1;
			end
			if (moved) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	initial begin : receiver
		int n;
		forever begin
			if (hold_pending != 0) begin
				hold_pending = 0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = recv_idle_on ? pick_idle() : 0;
				if (n == 0) begin
					res_stall <= 1'b0;
					@(posedge clk);
				end else begin
					res_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		logic stalled;
		gap = send_idle_on ? pick_idle() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last <= l;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic send_target();
		for (int i = 0; i < bytes_q.size(); i++) send_byte(bytes_q[i], i == bytes_q.size() - 1);
		bytes_q.delete();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limits(input logic [11:0] mp, input logic [9:0] mq);
		logic [11:0] qword;
		wait_idle();
		qword = 12'($urandom);
		qword[9:0] = mq;
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_PATH_LEN;
		cfg_data <= mp;
		@(posedge clk);
		cfg_index <= REG_MAX_QUERY_LEN;
		cfg_data <= qword;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limits(mp, mq);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) bytes_q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + v;
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
	endfunction

	function automatic void add_escape(input logic [7:0] v);
		bytes_q.push_back(CH_PERCENT);
		bytes_q.push_back(hex_char(v[7:4]));
		bytes_q.push_back(hex_char(v[3:0]));
	endfunction

	function automatic void add_segment();
		int r;
		int len;
		int k;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			add_text("..");
		end else if (r < 20) begin
			add_text(".");
		end else if (r < 24) begin
			add_text(".");
			add_escape(CH_DOT);
		end else if (r < 27) begin
			add_text("...");
		end else begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++) begin
				k = $urandom_range(0, 99);
				if (k < 80) bytes_q.push_back(safe_chars[$urandom_range(0, safe_chars.len() - 1)]);
				else if (k < 90) add_escape(8'($urandom_range(8'h21, 8'h7e)));
				else if (k < 95) add_escape($urandom_range(0, 1) ? CH_SLASH : CH_DOT);
				else add_escape(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	function automatic void add_well_formed();
		int nseg;
		int qlen;
		bytes_q.push_back(CH_SLASH);
		nseg = $urandom_range(0, 4);
		for (int i = 0; i < nseg; i++) begin
			if (i != 0) begin
				if ($urandom_range(0, 9) == 0) add_escape(CH_SLASH);
				else bytes_q.push_back(CH_SLASH);
			end
			add_segment();
		end
		if ($urandom_range(0, 4) == 0) bytes_q.push_back(CH_SLASH);
		if ($urandom_range(0, 99) < 40) begin
			bytes_q.push_back(CH_QMARK);
			qlen = $urandom_range(0, 12);
			for (int i = 0; i < qlen; i++) bytes_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 7))
			0: return CH_QMARK;
			1: return CH_PERCENT;
			2: return CH_SLASH;
			3: return CH_DOT;
			4: return hex_char(4'($urandom_range(0, 15)));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void make_random_target();
		int r;
		int pos;
		int len;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			add_well_formed();
		end else if (r < 88) begin
			add_well_formed();
			pos = $urandom_range(0, bytes_q.size() - 1);
			case ($urandom_range(0, 5))
				0: bytes_q[pos] = CH_PERCENT;
				1: begin
					bytes_q.push_back(CH_PERCENT);
					if ($urandom_range(0, 1)) bytes_q.push_back(hex_char(4'($urandom)));
				end
				2: bytes_q[pos] = $urandom_range(0, 3) == 0 ? CH_DEL :
					($urandom_range(0, 2) == 0 ? CH_BACKSLASH : 8'($urandom_range(0, 31)));
				3: bytes_q[0] = noise_byte();
				4: bytes_q[pos] = 8'($urandom_range(0, 255));
				default: begin
					bytes_q.push_back(CH_PERCENT);
					if ($urandom_range(0, 1)) bytes_q.push_back(hex_char(4'($urandom)));
					bytes_q.push_back(CH_QMARK);
					bytes_q.push_back(noise_byte());
				end
			endcase
		end else begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) bytes_q.push_back(noise_byte());
		end
	endfunction

	task automatic random_targets(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			make_random_target();
			sent += bytes_q.size();
			send_target();
		end
	endtask

	task automatic directed_targets();
		add_text("?");
		send_target();
		add_text("x");
		send_target();
		add_text("/%4");
		send_target();
		add_text("/%G");
		send_target();
		add_text("/%00");
		send_target();
		add_text("/%2F..?");
		bytes_q.push_back(8'hff);
		send_target();
		bytes_q.push_back(CH_SLASH);
		bytes_q.push_back(8'h00);
		bytes_q.push_back(CH_DEL);
		bytes_q.push_back(CH_BACKSLASH);
		send_target();
		add_text("/%4?");
		send_target();
	endtask

	initial begin : stimulus
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_targets();
		random_targets(250);

		write_limits(12'd1, 10'd0);
		random_targets(150);

		write_limits(12'd200, 10'd300);
		bytes_q.push_back(CH_SLASH);
		repeat (201) bytes_q.push_back(8'h61);
		send_target();
		add_text("/?");
		repeat (310) bytes_q.push_back(8'($urandom_range(0, 255)));
		send_target();
		random_targets(200);

		write_limits(12'd0, 10'($urandom_range(0, 1023)));
		random_targets(100);

		write_limits(12'($urandom_range(4, 40)), 10'($urandom_range(0, 8)));
		send_idle_on = 0;
		hold_pending = 1;
		random_targets(300);
		send_idle_on = 1;

		write_limits(12'($urandom_range(2, 30)), 10'($urandom_range(1, 12)));
		send_idle_on = 0;
		recv_idle_on = 0;
		random_targets(250);
		send_idle_on = 1;
		recv_idle_on = 1;

		for (int p = 0; p < 3; p++) begin
			write_limits(12'($urandom_range(1, 4095)) % 12'd48 + 12'd1,
				10'($urandom_range(0, 1023)) % 10'd16);
			random_targets(100);
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
